[src/dnle_pkg.sv]
package dnle_pkg;

  localparam logic [7:0] SepChar = 8'd46;
  localparam int CntW = 6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       name_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       name_end;
    logic       label_overflow;
  } out_beat_t;

  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] len;
    logic            term;
    logic            ovf;
  } lbl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BkLen,
    BkData,
    BkTerm
  } bk_state_e;

endpackage

[src/dnle_ram.sv]
module dnle_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/dnle_front.sv]
module dnle_front #(
  parameter int MaxLabel = 62,
  parameter int IdxW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dnle_pkg::in_beat_t  in_data_i,
  input  dnle_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output dnle_pkg::lbl_cmd_t  cmd_o,
  output logic                we_o,
  output logic [IdxW:0]       waddr_o,
  output logic [7:0]          wdata_o
);
  import dnle_pkg::*;

  logic            bank_q, bank_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic            is_sep;
  logic            has_room;
  logic [CntW-1:0] cnt_new;
  logic            ovf_new;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign is_sep     = (in_data_i.char_in == SepChar);
  assign has_room   = (cnt_q < CntW'(MaxLabel));

  always_comb begin
    we_o    = accept && !is_sep && has_room;
    waddr_o = {bank_q, cnt_q[IdxW-1:0]};
    wdata_o = in_data_i.char_in;
    cnt_new = cnt_q;
    ovf_new = ovf_q;
    if (!is_sep) begin
      if (has_room) begin
        cnt_new = cnt_q + CntW'(1);
      end else begin
        ovf_new = 1'b1;
      end
    end
    push_o     = accept && (is_sep || in_data_i.name_last);
    cmd_o.bank = bank_q;
    cmd_o.len  = cnt_new;
    cmd_o.term = in_data_i.name_last;
    cmd_o.ovf  = ovf_new;
    bank_d = bank_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    if (accept) begin
      cnt_d = cnt_new;
      ovf_d = ovf_new;
      if (push_o) begin
        bank_d = !bank_q;
        cnt_d  = '0;
      end
      if (in_data_i.name_last) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      bank_q <= bank_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

[src/dnle_queue.sv]
module dnle_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dnle_pkg::lbl_cmd_t cmd_i,
  input  logic               pop_i,
  output dnle_pkg::lbl_cmd_t head_o,
  output dnle_pkg::q_stat_t  stat_o
);
  import dnle_pkg::*;

  lbl_cmd_t   slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = !wr_q;
    end
    if (pop_i) begin
      rd_d = !rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("Label command pushed into a full queue.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("Label command popped from an empty queue.");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("Queue fill count out of range.");

endmodule

[src/dnle_back.sv]
module dnle_back #(
  parameter int IdxW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dnle_pkg::lbl_cmd_t  head_i,
  input  dnle_pkg::q_stat_t   q_stat_i,
  output logic                pop_o,
  output logic                re_o,
  output logic [IdxW:0]       raddr_o,
  input  logic [7:0]          rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dnle_pkg::out_beat_t out_data_o
);
  import dnle_pkg::*;

  bk_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_q, out_d;
  logic            slot_free;
  logic            len_zero;
  logic            data_end;

  assign slot_free = !out_valid_q || out_ready_i;
  assign len_zero  = (head_i.len == '0);
  assign data_end  = (cnt_q == CntW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkLen: begin
        if (slot_free && !q_stat_i.empty) begin
          if (!len_zero) begin
            state_d = BkData;
          end else if (head_i.term) begin
            state_d = BkTerm;
          end
        end
      end
      BkData: begin
        if (slot_free && data_end) begin
          state_d = head_i.term ? BkTerm : BkLen;
        end
      end
      BkTerm: begin
        if (slot_free) begin
          state_d = BkLen;
        end
      end
      default: state_d = BkLen;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    re_o        = 1'b0;
    raddr_o     = {head_i.bank, idx_q};
    unique case (state_q)
      BkLen: begin
        if (slot_free && !q_stat_i.empty) begin
          out_valid_d          = 1'b1;
          out_d.out_byte       = {{(8 - CntW){1'b0}}, head_i.len};
          out_d.run_last       = len_zero && !head_i.term;
          out_d.name_end       = 1'b0;
          out_d.label_overflow = 1'b0;
          if (!len_zero) begin
            re_o    = 1'b1;
            raddr_o = {head_i.bank, {IdxW{1'b0}}};
            idx_d   = IdxW'(1);
            cnt_d   = head_i.len;
          end else if (!head_i.term) begin
            pop_o = 1'b1;
          end
        end
      end
      BkData: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.out_byte       = rdata_i;
          out_d.run_last       = data_end && !head_i.term;
          out_d.name_end       = 1'b0;
          out_d.label_overflow = 1'b0;
          cnt_d                = cnt_q - CntW'(1);
          if (!data_end) begin
            re_o  = 1'b1;
            idx_d = idx_q + IdxW'(1);
          end else if (!head_i.term) begin
            pop_o = 1'b1;
          end
        end
      end
      BkTerm: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.out_byte       = 8'd0;
          out_d.run_last       = 1'b1;
          out_d.name_end       = 1'b1;
          out_d.label_overflow = head_i.ovf;
          pop_o                = 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkLen;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkData) |-> (cnt_q != '0))
    else $error("Label data state entered with no bytes left.");

  a_term_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BkLen) |-> !q_stat_i.empty)
    else $error("Label emission running without a queued command.");

endmodule

[src/dns_name_label_encoder.sv]
// DNS name label encoder: turns a dotted host name into DNS wire-form bytes.
// The input channel takes one character per beat with name_last on the final
// character; the output channel gives one encoded byte per beat, with
// run_last on the last byte caused by an input beat and name_end plus
// label_overflow on the zero terminator.
// An input beat is taken whenever the label command queue has room.
// Characters go into one half of a two-bank label RAM; a dot or the
// final character queues a command for the back end, which streams the
// length byte and, from the RAM read port, the label bytes at one byte
// per cycle while the receiver is ready, plus a terminator after the
// final label. A label of n stored characters gives n + 1 output bytes;
// its length byte passes the queue and the output register. With two labels
// waiting, the input side stalls until the back end releases a bank.
// When the receiver stalls, the output register holds its beat and the back
// end waits; the front end keeps taking characters until the queue fills.
// Reset clears the counters, the queue and the overflow flag; the label RAM
// keeps whatever it holds, and no unwritten entry is ever read.
module dns_name_label_encoder #(
  parameter int MaxLabel = 62
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dnle_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dnle_pkg::out_beat_t out_data_o
);
  import dnle_pkg::*;

  localparam int IdxW  = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
  localparam int Depth = 2 ** (IdxW + 1);

  q_stat_t       q_stat;
  lbl_cmd_t      push_cmd;
  lbl_cmd_t      head_cmd;
  logic          push;
  logic          pop;
  logic          we;
  logic [IdxW:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [IdxW:0] raddr;
  logic [7:0]    rdata;

  dnle_front #(
    .MaxLabel(MaxLabel),
    .IdxW    (IdxW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata)
  );

  dnle_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (push_cmd),
    .pop_i (pop),
    .head_o(head_cmd),
    .stat_o(q_stat)
  );

  dnle_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  dnle_back #(
    .IdxW(IdxW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import dnle_pkg::*;

  localparam int MaxLabel = 62;
  localparam int CycleLimit = 2000000;
  localparam int RandomItems = 50;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  logic [7:0] label_buf [MaxLabel];
  int         label_len = 0;
  logic       name_ovf = 1'b0;
  out_beat_t  item_run[$];
  out_beat_t  wire_bytes[$];
  int         errors = 0;
  int         chars_sent = 0;
  int         cycle_count = 0;
  int         hold_req = 0;
  bit         calm = 1'b0;

  dns_name_label_encoder #(
    .MaxLabel(MaxLabel)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_char(bit wild);
    if (wild && $urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic void push_beat(logic [7:0] b, logic rl, logic ne, logic ov);
    out_beat_t beat;
    beat.out_byte = b;
    beat.run_last = rl;
    beat.name_end = ne;
    beat.label_overflow = ov;
    item_run.push_back(beat);
  endfunction

  function automatic void flush_label();
    push_beat(8'(label_len), 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < label_len; i++) begin
      push_beat(label_buf[i], 1'b0, 1'b0, 1'b0);
    end
    label_len = 0;
  endfunction

  function automatic void encode_char(logic [7:0] c, logic last);
    out_beat_t tail;
    item_run.delete();
    if (c == SepChar) begin
      flush_label();
    end else begin
      if (label_len < MaxLabel) begin
        label_buf[label_len] = c;
        label_len++;
      end else begin
        name_ovf = 1'b1;
      end
      if (last) flush_label();
    end
    if (last) begin
      push_beat(8'h00, 1'b1, 1'b1, name_ovf);
      name_ovf = 1'b0;
    end else if (item_run.size() > 0) begin
      tail = item_run.pop_back();
      tail.run_last = 1'b1;
      item_run.push_back(tail);
    end
    foreach (item_run[i]) wire_bytes.push_back(item_run[i]);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int       gap;
    in_beat_t beat;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.char_in = c;
    beat.name_last = last;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    encode_char(c, last);
    chars_sent++;
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_chars(input int n, input logic last, input bit wild);
    for (int i = 0; i < n; i++) begin
      send_char(random_char(wild), last && i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (wire_bytes.size() != 0);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want,
                           input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (wire_bytes.size() == 0) begin
      $display("%0t: unexpected beat, got %h", $time, got);
      errors++;
      return;
    end
    want = wire_bytes.pop_front();
    cmp_field("out_byte", want.out_byte, got.out_byte);
    cmp_field("run_last", 8'(want.run_last), 8'(got.run_last));
    cmp_field("name_end", 8'(want.name_end), 8'(got.name_end));
    cmp_field("label_overflow", 8'(want.label_overflow), 8'(got.label_overflow));
  endtask

  task automatic test_dot_cases();
    send_name(".");
    send_name(".ab");
    send_name("a..b");
    send_name("ab.");
  endtask

  task automatic test_char_extremes();
    send_name("x");
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'haa, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'h2d, 1'b0);
    send_char(8'h2f, 1'b1);
  endtask

  task automatic test_long_labels();
    send_chars(MaxLabel + 1, 1'b0, 1'b0);
    send_char(SepChar, 1'b1);
    send_name("z");
  endtask

  task automatic test_backpressure_fill();
    hold_req = 300;
    calm = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_chars(3, 1'b0, 1'b0);
      send_char(SepChar, i == 5);
    end
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_names();
    int first;
    int labels;
    int len;
    int r;
    first = chars_sent;
    while (chars_sent - first < RandomItems) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        labels = $urandom_range(1, 4);
        for (int l = 0; l < labels; l++) begin
          r = $urandom_range(0, 39);
          if (r == 0) len = 0;
          else if (r == 1) len = $urandom_range(40, 70);
          else len = $urandom_range(1, 8);
          send_chars(len, 1'b0, 1'b1);
          if (l < labels - 1) send_char(SepChar, 1'b0);
        end
        if ($urandom_range(0, 5) == 0) send_char(SepChar, 1'b1);
        else send_char(random_char(1'b1), 1'b1);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_beat(out_data_o);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dot_cases();
    test_char_extremes();
    test_long_labels();
    test_backpressure_fill();
    test_random_names();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && wire_bytes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/dnle_pkg.sv
src/dnle_ram.sv
src/dnle_front.sv
src/dnle_queue.sv
src/dnle_back.sv
src/dns_name_label_encoder.sv
tb/testbench.sv
